[rtl/sfc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared types and constants for the sphere frustum cull block.
// ----------------------------------------------------------------------------
package sfc_pkg;

   localparam int FIELD_W     = 16;
   localparam int PLANE_COUNT = 6;
   localparam int PLANE_W     = 3;
   localparam int COEF_COUNT  = 4;
   localparam int CNT_W       = 3;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_TEST = 1'b1;

   // multiplies issued per phase
   localparam logic [CNT_W-1:0] MULS_RSQ = 3'd1;
   localparam logic [CNT_W-1:0] MULS_DOT = 3'd3;
   localparam logic [CNT_W-1:0] MULS_SQ  = 3'd4;
   localparam logic [CNT_W-1:0] MULS_NRM = 3'd3;
   localparam logic [CNT_W-1:0] MULS_RHS = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RSQ,
      ST_DOT,
      ST_SQ,
      ST_NRM,
      ST_RHS,
      ST_DONE
   } sfc_state_type;

   typedef enum logic [1:0] {
      SH_NONE,
      SH_ONE,
      SH_TWO
   } sfc_shift_type;

   typedef struct packed {
      logic          issue;
      logic          neg;
      sfc_shift_type shift;
      logic          load;
   } sfc_mac_ctl_type;

endpackage

[rtl/sfc_mac.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfc_mac
// Shared multiply-accumulate unit: registered HxH product, then signed
// accumulate of the product shifted by zero, one or two limbs.
// ----------------------------------------------------------------------------
module sfc_mac #(
   parameter int H = 18
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sfc_pkg::sfc_mac_ctl_type ctl,
   input  logic [H-1:0]           op_a,
   input  logic [H-1:0]           op_b,
   input  logic [4*H:0]           init,
   output logic [4*H:0]           acc
);

   localparam int AW = 4 * H + 1;

   logic [2*H-1:0]        prod_ff;
   logic                  pv_ff;
   logic                  neg_ff;
   sfc_pkg::sfc_shift_type sh_ff;
   logic [AW-1:0]         acc_ff;
   logic [AW-1:0]         acc_in;
   logic [AW-1:0]         term;

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
      neg_ff  <= ctl.neg;
      sh_ff   <= ctl.shift;
      acc_ff  <= acc_in;
      if (reset) begin
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= ctl.issue;
      end
   end

   always_comb begin
      case (sh_ff)
         sfc_pkg::SH_ONE: term = {{(AW-2*H){1'b0}}, prod_ff} << H;
         sfc_pkg::SH_TWO: term = {{(AW-2*H){1'b0}}, prod_ff} << (2 * H);
         default:         term = {{(AW-2*H){1'b0}}, prod_ff};
      endcase
   end

   always_comb begin
      acc_in = acc_ff;
      if (ctl.load) begin
         acc_in = init;
      end else if (pv_ff) begin
         acc_in = neg_ff ? (acc_ff - term) : (acc_ff + term);
      end
   end

   assign acc = acc_ff;

endmodule

[rtl/sphere_frustum_cull.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_frustum_cull
// Keeps six frustum planes built from matrix rows and tests spheres against
// them with an exact integer squared-distance compare.
//
//   channel | dir | handshake          | word
//   req     | in  | req_valid/ready    | kind, row, elem_*, center_*, radius
//   rsp     | out | rsp_valid/ready    | inside_res (tests only)
//
// A row load leaves the block idle. A test squares the radius, then per plane
// forms the dot product and, when it is positive, squares it, sums the squares
// of the normal and compares against radius squared times that, all on the one
// shared multiplier. Reset clears the plane store. req_ready is low from test
// start until the result word is taken.
// ----------------------------------------------------------------------------
module sphere_frustum_cull #(
   parameter int VALUE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [1:0]  req_row,
   input  logic [15:0] req_elem_one,
   input  logic [15:0] req_elem_two,
   input  logic [15:0] req_elem_three,
   input  logic [15:0] req_elem_four,
   input  logic [15:0] req_center_x,
   input  logic [15:0] req_center_y,
   input  logic [15:0] req_center_z,
   input  logic [15:0] req_radius,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_inside_res
);

   localparam int V     = VALUE_BITS;
   localparam int H     = V + 2;
   localparam int AW    = 4 * H + 1;
   localparam int EXT_W = V + sfc_pkg::FIELD_W;
   localparam int PN    = sfc_pkg::PLANE_COUNT;
   localparam int PW    = sfc_pkg::PLANE_W;
   localparam int CW    = sfc_pkg::CNT_W;

   sfc_pkg::sfc_state_type state_ff, state_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [PW-1:0]  plane_ff, plane_in;
   logic           inside_ff, inside_in;
   logic [V:0]     coef_ff [PN][sfc_pkg::COEF_COUNT];
   logic [V-1:0]   cen_ff [3];
   logic [V-1:0]   rad_ff;
   logic [2*H-1:0] rsq_ff, rsq_in;
   logic [2*H-1:0] smag_ff, smag_in;
   logic [2*H-1:0] nn_ff, nn_in;
   logic [4*H-1:0] lhs_ff, lhs_in;

   logic           accept;
   logic [CW-1:0]  muls;
   logic           compute;
   logic           phase_end;
   logic           last_plane;
   logic           nz;
   logic           s_pos;
   logic           reject;
   logic [AW-1:0]  acc;
   logic [AW-1:0]  init;
   logic [V:0]     d_next;
   logic [H-1:0]   op_a, op_b;
   sfc_pkg::sfc_mac_ctl_type ctl;
   logic [H-1:0]   qmag [3];
   logic [H-1:0]   cmag [3];
   logic           qneg [3];
   logic           cneg [3];
   logic [1:0]     mi;

   logic [EXT_W-1:0] x1, x2, x3, x4, xx, xy, xz, xr;
   logic [H-1:0]     e1, e2, e3, e4, n4;

   function automatic logic [V:0] sat_coef(input logic [H-1:0] v);
      logic [V:0] r;
      if (v[H-1] != v[H-2]) begin
         r = v[H-1] ? {1'b1, {V{1'b0}}} : {1'b0, {V{1'b1}}};
      end else begin
         r = v[V:0];
      end
      return r;
   endfunction

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == sfc_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == sfc_pkg::ST_DONE);
   assign rsp_inside_res = inside_ff;

   assign x1 = {{V{1'b0}}, req_elem_one};
   assign x2 = {{V{1'b0}}, req_elem_two};
   assign x3 = {{V{1'b0}}, req_elem_three};
   assign x4 = {{V{1'b0}}, req_elem_four};
   assign xx = {{V{1'b0}}, req_center_x};
   assign xy = {{V{1'b0}}, req_center_y};
   assign xz = {{V{1'b0}}, req_center_z};
   assign xr = {{V{1'b0}}, req_radius};

   assign e1 = {{2{x1[V-1]}}, x1[V-1:0]};
   assign e2 = {{2{x2[V-1]}}, x2[V-1:0]};
   assign e3 = {{2{x3[V-1]}}, x3[V-1:0]};
   assign e4 = {{2{x4[V-1]}}, x4[V-1:0]};
   assign n4 = -e4;

   // plane store and captured test operands
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < PN; p++) begin
            for (int k = 0; k < sfc_pkg::COEF_COUNT; k++) begin
               coef_ff[p][k] <= '0;
            end
         end
      end else if (accept && req_kind == sfc_pkg::KIND_LOAD) begin
         coef_ff[0][req_row] <= sat_coef(-e3);
         coef_ff[1][req_row] <= sat_coef(n4 + e3);
         coef_ff[2][req_row] <= sat_coef(n4 - e1);
         coef_ff[3][req_row] <= sat_coef(n4 + e1);
         coef_ff[4][req_row] <= sat_coef(n4 + e2);
         coef_ff[5][req_row] <= sat_coef(n4 - e2);
      end
      if (accept && req_kind == sfc_pkg::KIND_TEST) begin
         cen_ff[0] <= xx[V-1:0];
         cen_ff[1] <= xy[V-1:0];
         cen_ff[2] <= xz[V-1:0];
         rad_ff    <= xr[V-1:0];
      end
      rsq_ff  <= rsq_in;
      smag_ff <= smag_in;
      nn_ff   <= nn_in;
      lhs_ff  <= lhs_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= sfc_pkg::ST_IDLE;
         cnt_ff    <= '0;
         plane_ff  <= '0;
         inside_ff <= 1'b1;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         plane_ff  <= plane_in;
         inside_ff <= inside_in;
      end
   end

   // magnitudes of the current plane's normal and of the center
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         qneg[k] = coef_ff[plane_ff][k][V];
         qmag[k] = qneg[k] ? (~{coef_ff[plane_ff][k][V], coef_ff[plane_ff][k]} + 1'b1)
                           : {coef_ff[plane_ff][k][V], coef_ff[plane_ff][k]};
         cneg[k] = cen_ff[k][V-1];
         cmag[k] = cneg[k] ? (~{{2{cen_ff[k][V-1]}}, cen_ff[k]} + 1'b1)
                           : {{2{cen_ff[k][V-1]}}, cen_ff[k]};
      end
   end

   always_comb begin
      unique case (state_ff)
         sfc_pkg::ST_RSQ: muls = sfc_pkg::MULS_RSQ;
         sfc_pkg::ST_DOT: muls = sfc_pkg::MULS_DOT;
         sfc_pkg::ST_SQ:  muls = sfc_pkg::MULS_SQ;
         sfc_pkg::ST_NRM: muls = sfc_pkg::MULS_NRM;
         sfc_pkg::ST_RHS: muls = sfc_pkg::MULS_RHS;
         default:         muls = '0;
      endcase
   end

   assign compute    = (muls != '0);
   assign phase_end  = compute && (cnt_ff == muls + 1'b1);
   assign last_plane = (plane_ff == PW'(PN - 1));
   assign nz         = (qmag[0] != '0) || (qmag[1] != '0) || (qmag[2] != '0);
   assign s_pos      = !acc[AW-1] && (acc != '0);
   assign reject     = (lhs_ff > acc[4*H-1:0]);
   assign mi         = cnt_ff[1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sfc_pkg::ST_IDLE: begin
            if (accept && req_kind == sfc_pkg::KIND_TEST) state_in = sfc_pkg::ST_RSQ;
         end
         sfc_pkg::ST_RSQ: begin
            if (phase_end) state_in = sfc_pkg::ST_DOT;
         end
         sfc_pkg::ST_DOT: begin
            if (phase_end) begin
               if (nz && s_pos)     state_in = sfc_pkg::ST_SQ;
               else if (last_plane) state_in = sfc_pkg::ST_DONE;
            end
         end
         sfc_pkg::ST_SQ: begin
            if (phase_end) state_in = sfc_pkg::ST_NRM;
         end
         sfc_pkg::ST_NRM: begin
            if (phase_end) state_in = sfc_pkg::ST_RHS;
         end
         sfc_pkg::ST_RHS: begin
            if (phase_end) state_in = (reject || last_plane) ? sfc_pkg::ST_DONE
                                                             : sfc_pkg::ST_DOT;
         end
         sfc_pkg::ST_DONE: begin
            if (rsp_ready) state_in = sfc_pkg::ST_IDLE;
         end
         default: state_in = sfc_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs and operand selection
   always_comb begin
      cnt_in    = compute ? (phase_end ? '0 : cnt_ff + 1'b1) : '0;
      plane_in  = plane_ff;
      inside_in = inside_ff;
      rsq_in    = rsq_ff;
      smag_in   = smag_ff;
      nn_in     = nn_ff;
      lhs_in    = lhs_ff;
      op_a      = '0;
      op_b      = '0;
      ctl.issue = compute && (cnt_ff < muls);
      ctl.neg   = 1'b0;
      ctl.shift = sfc_pkg::SH_NONE;
      ctl.load  = phase_end || accept;
      unique case (state_ff)
         sfc_pkg::ST_RSQ: begin
            op_a = {2'b00, rad_ff};
            op_b = {2'b00, rad_ff};
            if (phase_end) begin
               rsq_in   = acc[2*H-1:0];
               plane_in = '0;
            end
         end
         sfc_pkg::ST_DOT: begin
            op_a    = qmag[mi];
            op_b    = cmag[mi];
            ctl.neg = qneg[mi] ^ cneg[mi];
            if (phase_end) begin
               smag_in = acc[2*H-1:0];
               if (!(nz && s_pos)) begin
                  if (last_plane) inside_in = 1'b1;
                  else            plane_in  = plane_ff + 1'b1;
               end
            end
         end
         sfc_pkg::ST_SQ: begin
            op_a = mi[1] ? smag_ff[2*H-1:H] : smag_ff[H-1:0];
            op_b = (mi == 2'd1 || mi == 2'd3) ? smag_ff[2*H-1:H] : smag_ff[H-1:0];
            case (mi)
               2'd0:    ctl.shift = sfc_pkg::SH_NONE;
               2'd3:    ctl.shift = sfc_pkg::SH_TWO;
               default: ctl.shift = sfc_pkg::SH_ONE;
            endcase
            if (phase_end) lhs_in = acc[4*H-1:0];
         end
         sfc_pkg::ST_NRM: begin
            op_a = qmag[mi];
            op_b = qmag[mi];
            if (phase_end) nn_in = acc[2*H-1:0];
         end
         sfc_pkg::ST_RHS: begin
            op_a = mi[1] ? rsq_ff[2*H-1:H] : rsq_ff[H-1:0];
            op_b = (mi == 2'd1 || mi == 2'd3) ? nn_ff[2*H-1:H] : nn_ff[H-1:0];
            case (mi)
               2'd0:    ctl.shift = sfc_pkg::SH_NONE;
               2'd3:    ctl.shift = sfc_pkg::SH_TWO;
               default: ctl.shift = sfc_pkg::SH_ONE;
            endcase
            if (phase_end) begin
               if (reject)          inside_in = 1'b0;
               else if (last_plane) inside_in = 1'b1;
               else                 plane_in  = plane_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // accumulator starts a plane at its offset, every other phase at zero
   assign d_next = coef_ff[plane_in][3];
   assign init   = (state_in == sfc_pkg::ST_DOT) ? {{(AW-V-1){d_next[V]}}, d_next} : '0;

   sfc_mac #(
      .H (H)
   ) u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .op_a  (op_a),
      .op_b  (op_b),
      .init  (init),
      .acc   (acc)
   );

   a_done_blocks_req : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while result pending");

   a_load_stays_idle : assert property (@(posedge clock) disable iff (reset)
      (accept && req_kind == sfc_pkg::KIND_LOAD) |=> (state_ff == sfc_pkg::ST_IDLE))
      else $error("row load left idle");

   a_cnt_range : assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= muls + 1'b1)
      else $error("phase counter overran");

   a_plane_range : assert property (@(posedge clock) disable iff (reset)
      plane_ff < PW'(PN))
      else $error("plane index out of range");

endmodule
